// ----- hdl/kmeans_cluster_pass_defines.svh -----
// Assertion macros for the k-means pass engine.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef KMEANS_CLUSTER_PASS_DEFINES_SVH
`define KMEANS_CLUSTER_PASS_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KCP_ASSERT_NOW(lbl, pre, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (con)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define KCP_ASSERT_NEXT(lbl, pre, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (con)) \
    else $error(msg);

`endif

// ----- hdl/kcp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcp_pkg
// Shared types and fixed widths for the k-means pass engine.
// ----------------------------------------------------------------------------
package kcp_pkg;

  localparam int COORD_W = 32;
  localparam int THR_W   = 31;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_POINT = 2'd1,
    OP_END   = 2'd2,
    OP_READ  = 2'd3
  } kcp_op_t;

  typedef enum logic [1:0] {
    KIND_POINT  = 2'd0,
    KIND_STATUS = 2'd1,
    KIND_CENTER = 2'd2
  } kcp_kind_t;

  typedef enum logic [1:0] {
    CFG_CLUSTERS  = 2'd0,
    CFG_DIMS      = 2'd1,
    CFG_THRESHOLD = 2'd2,
    CFG_MAXPASS   = 2'd3
  } kcp_cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_WAIT,
    ST_D_RD,
    ST_D_SUB,
    ST_D_MUL,
    ST_D_ACC,
    ST_A_RD,
    ST_A_WR,
    ST_P_EMIT,
    ST_E_RD,
    ST_E_CHK,
    ST_E_DIV,
    ST_E_WR,
    ST_E_EMIT
  } kcp_state_t;

endpackage

// ----- hdl/kmeans_cluster_pass.sv -----
`timescale 1ns / 1ps
// A center load writes the center memory; a center read returns its result word
// from the registered memory read. A point's last coordinate starts the distance
// scan over each center and coordinate through the shared multiplier, then the
// sums are updated coordinate by coordinate; other point coordinates are only
// buffered. End of pass runs the bit-serial divider for each center coordinate
// of a non-empty cluster. One word is worked on at a time. Reset clears control.
// ----------------------------------------------------------------------------
// kmeans_cluster_pass
// One Lloyd k-means pass engine in Q16.16 fixed point, built around a center
// memory and a sum memory that are read, modified and written back.
// ----------------------------------------------------------------------------
`include "kmeans_cluster_pass_defines.svh"

module kmeans_cluster_pass
  import kcp_pkg::*;
#(
  parameter int MAX_CLUSTERS        = 16,
  parameter int MAX_DIMS            = 16,
  parameter int MAX_POINTS_PER_PASS = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input words.
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [3:0]  in_cluster_select,
  input  logic [3:0]  in_dim_select,
  input  logic signed [31:0] in_coordinate,
  // Result words.
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [3:0]  out_assigned_cluster,
  output logic signed [31:0] out_center_value,
  output logic        out_converged,
  output logic [7:0]  out_pass_count,
  // Configuration writes.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  // Widths derived from the parameters.
  localparam int DEPTH  = MAX_CLUSTERS * MAX_DIMS;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CI_W   = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int DI_W   = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int CNT_W  = $clog2(MAX_POINTS_PER_PASS + 1);
  // A sum holds at most MAX_POINTS_PER_PASS coordinates of 32 bits each.
  localparam int SUM_W  = COORD_W + $clog2(MAX_POINTS_PER_PASS);
  localparam int SQ_W   = 2 * COORD_W + 1;
  localparam int ACC_W  = SQ_W + ((MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 0);
  localparam int DCNT_W = $clog2(SUM_W + 1);

  // Configuration registers.
  logic [4:0]       cluster_count_r;
  logic [4:0]       dimension_count_r;
  logic [THR_W-1:0] change_threshold_r;
  logic [7:0]       max_passes_r;

  // Effective counts: zero acts as one, anything above the maximum as the maximum.
  logic [31:0] k_last, d_last;
  always_comb begin
    if (cluster_count_r == 5'd0) begin
      k_last = 32'd0;
    end else if (32'(cluster_count_r) > MAX_CLUSTERS) begin
      k_last = 32'(MAX_CLUSTERS - 1);
    end else begin
      k_last = 32'(cluster_count_r) - 32'd1;
    end
    if (dimension_count_r == 5'd0) begin
      d_last = 32'd0;
    end else if (32'(dimension_count_r) > MAX_DIMS) begin
      d_last = 32'(MAX_DIMS - 1);
    end else begin
      d_last = 32'(dimension_count_r) - 32'd1;
    end
  end

  // Memories and their ports.
  logic [COORD_W-1:0] center_mem [DEPTH];
  logic [SUM_W-1:0]   sum_mem    [DEPTH];
  logic               c_we, c_re, s_we, s_re;
  logic [AW-1:0]      c_waddr, c_raddr, s_waddr, s_raddr;
  logic [COORD_W-1:0] c_wdata, c_rd_r;
  logic [SUM_W-1:0]   s_wdata, s_rd_r;

  always_ff @(posedge clk) begin
    if (c_we) begin
      center_mem[c_waddr] <= c_wdata;
    end
    if (c_re) begin
      c_rd_r <= center_mem[c_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (s_we) begin
      sum_mem[s_waddr] <= s_wdata;
    end
    if (s_re) begin
      s_rd_r <= sum_mem[s_raddr];
    end
  end

  // Sum entries not yet written in this pass read as zero.
  logic [DEPTH-1:0]   sum_vld_r;
  logic               s_rd_vld_r;
  logic [CNT_W-1:0]   count_r [MAX_CLUSTERS];
  logic [COORD_W-1:0] pbuf_r  [MAX_DIMS];

  // Control and datapath registers.
  kcp_state_t         state_r, state_nxt;
  logic [CI_W-1:0]    i_r, i_nxt, best_r, best_nxt;
  logic [DI_W-1:0]    j_r, j_nxt;
  logic [ACC_W-1:0]   acc_r, acc_nxt, best_dist_r, best_dist_nxt;
  logic [COORD_W:0]   mag_r, mag_nxt;
  logic [SQ_W-1:0]    sq_r, sq_nxt;
  logic [COORD_W-1:0] newv_r, newv_nxt;
  logic               changed_r, changed_nxt;
  logic [SUM_W-1:0]   div_num_r, div_num_nxt;
  logic [CNT_W:0]     div_rem_r, div_rem_nxt;
  logic [CNT_W-1:0]   div_den_r, div_den_nxt;
  logic               div_neg_r, div_neg_nxt;
  logic [DCNT_W-1:0]  div_cnt_r, div_cnt_nxt;
  logic               rd_ok_r, rd_ok_nxt;
  logic [7:0]         passes_done_r, passes_done_nxt;
  logic               first_pass_r, first_pass_nxt;

  logic               out_valid_r, out_valid_nxt;
  kcp_kind_t          out_kind_r, out_kind_nxt;
  logic [3:0]         out_cluster_r, out_cluster_nxt;
  logic [COORD_W-1:0] out_value_r, out_value_nxt;
  logic               out_conv_r, out_conv_nxt;
  logic [7:0]         out_pass_r, out_pass_nxt;

  // Strobes into the per-entry registers.
  logic               pbuf_we;
  logic [DI_W-1:0]    pbuf_waddr;
  logic               cnt_inc, pass_clear, vld_set;

  logic               in_fire, out_free;
  logic [31:0]        sel_c, sel_d;
  logic [AW-1:0]      ij_addr, sel_addr;
  logic               sel_ok;
  logic [COORD_W-1:0] pb_j;
  logic [COORD_W:0]   diff33, conv_diff, conv_mag, ref33;
  logic [ACC_W-1:0]   tot;
  logic [SUM_W-1:0]   sum_old, sum_abs;
  logic [CNT_W:0]     rem_sh;
  logic               last_j, last_i;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  // The output register can take a new word this cycle.
  assign out_free  = !out_valid_r || out_ready;

  assign out_valid            = out_valid_r;
  assign out_kind             = out_kind_r;
  assign out_assigned_cluster = out_cluster_r;
  assign out_center_value     = out_value_r;
  assign out_converged        = out_conv_r;
  assign out_pass_count       = out_pass_r;

  assign sel_c    = 32'(in_cluster_select);
  assign sel_d    = 32'(in_dim_select);
  assign sel_ok   = (sel_c < MAX_CLUSTERS) && (sel_d < MAX_DIMS);
  assign sel_addr = AW'(sel_c * MAX_DIMS + sel_d);
  assign ij_addr  = AW'(32'(i_r) * MAX_DIMS + 32'(j_r));
  assign pb_j     = pbuf_r[j_r];
  assign last_j   = (32'(j_r) == d_last);
  assign last_i   = (32'(i_r) == k_last);
  assign tot      = acc_r + ACC_W'(sq_r);
  assign sum_old  = s_rd_vld_r ? s_rd_r : '0;
  assign sum_abs  = sum_old[SUM_W-1] ? (~sum_old + SUM_W'(1)) : sum_old;
  assign rem_sh   = {div_rem_r[CNT_W-1:0], div_num_r[SUM_W-1]};
  assign diff33   = {c_rd_r[COORD_W-1], c_rd_r} - {pb_j[COORD_W-1], pb_j};
  assign ref33    = first_pass_r ? '0 : {c_rd_r[COORD_W-1], c_rd_r};
  assign conv_diff = {newv_r[COORD_W-1], newv_r} - ref33;
  assign conv_mag  = conv_diff[COORD_W] ? (~conv_diff + 33'd1) : conv_diff;

  always_comb begin
    state_nxt       = state_r;
    i_nxt           = i_r;
    j_nxt           = j_r;
    best_nxt        = best_r;
    acc_nxt         = acc_r;
    best_dist_nxt   = best_dist_r;
    mag_nxt         = mag_r;
    sq_nxt          = sq_r;
    newv_nxt        = newv_r;
    changed_nxt     = changed_r;
    div_num_nxt     = div_num_r;
    div_rem_nxt     = div_rem_r;
    div_den_nxt     = div_den_r;
    div_neg_nxt     = div_neg_r;
    div_cnt_nxt     = div_cnt_r;
    rd_ok_nxt       = rd_ok_r;
    passes_done_nxt = passes_done_r;
    first_pass_nxt  = first_pass_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_kind_nxt    = out_kind_r;
    out_cluster_nxt = out_cluster_r;
    out_value_nxt   = out_value_r;
    out_conv_nxt    = out_conv_r;
    out_pass_nxt    = out_pass_r;
    c_we = 1'b0; c_waddr = ij_addr; c_wdata = newv_r;
    c_re = 1'b0; c_raddr = ij_addr;
    s_we = 1'b0; s_waddr = ij_addr; s_wdata = '0;
    s_re = 1'b0; s_raddr = ij_addr;
    pbuf_we = 1'b0; pbuf_waddr = DI_W'(in_dim_select);
    cnt_inc = 1'b0; pass_clear = 1'b0; vld_set = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (kcp_op_t'(in_opcode))
            OP_LOAD: begin
              c_we    = sel_ok;
              c_waddr = sel_addr;
              c_wdata = in_coordinate;
            end
            OP_POINT: begin
              if (sel_d <= d_last) begin
                pbuf_we = 1'b1;
                if (sel_d == d_last) begin
                  i_nxt     = '0;
                  j_nxt     = '0;
                  acc_nxt   = '0;
                  state_nxt = ST_D_RD;
                end
              end
            end
            OP_END: begin
              i_nxt       = '0;
              j_nxt       = '0;
              changed_nxt = 1'b0;
              state_nxt   = ST_E_RD;
            end
            OP_READ: begin
              c_re      = sel_ok;
              c_raddr   = sel_addr;
              rd_ok_nxt = sel_ok;
              state_nxt = ST_RD_WAIT;
            end
            default: ;
          endcase
        end
      end
      ST_RD_WAIT: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_kind_nxt    = KIND_CENTER;
          out_cluster_nxt = '0;
          out_value_nxt   = rd_ok_r ? c_rd_r : '0;
          out_conv_nxt    = 1'b0;
          out_pass_nxt    = '0;
          state_nxt       = ST_IDLE;
        end
      end
      ST_D_RD: begin
        c_re      = 1'b1;
        state_nxt = ST_D_SUB;
      end
      ST_D_SUB: begin
        mag_nxt   = diff33[COORD_W] ? (~diff33 + 33'd1) : diff33;
        state_nxt = ST_D_MUL;
      end
      ST_D_MUL: begin
        sq_nxt    = SQ_W'(mag_r * mag_r);
        state_nxt = ST_D_ACC;
      end
      ST_D_ACC: begin
        if (last_j) begin
          acc_nxt = '0;
          if (i_r == '0 || tot < best_dist_r) begin
            best_nxt      = i_r;
            best_dist_nxt = tot;
          end
          j_nxt = '0;
          if (last_i) begin
            state_nxt = ST_A_RD;
          end else begin
            i_nxt     = i_r + CI_W'(1);
            state_nxt = ST_D_RD;
          end
        end else begin
          acc_nxt   = tot;
          j_nxt     = j_r + DI_W'(1);
          state_nxt = ST_D_RD;
        end
      end
      ST_A_RD: begin
        // A full cluster still reports the point but takes no more of it.
        if (32'(count_r[best_r]) >= MAX_POINTS_PER_PASS) begin
          state_nxt = ST_P_EMIT;
        end else begin
          s_re      = 1'b1;
          s_raddr   = AW'(32'(best_r) * MAX_DIMS + 32'(j_r));
          state_nxt = ST_A_WR;
        end
      end
      ST_A_WR: begin
        s_we    = 1'b1;
        vld_set = 1'b1;
        s_waddr = AW'(32'(best_r) * MAX_DIMS + 32'(j_r));
        s_wdata = sum_old + {{(SUM_W-COORD_W){pb_j[COORD_W-1]}}, pb_j};
        if (last_j) begin
          cnt_inc   = 1'b1;
          state_nxt = ST_P_EMIT;
        end else begin
          j_nxt     = j_r + DI_W'(1);
          state_nxt = ST_A_RD;
        end
      end
      ST_P_EMIT: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_kind_nxt    = KIND_POINT;
          out_cluster_nxt = 4'(32'(best_r));
          out_value_nxt   = '0;
          out_conv_nxt    = 1'b0;
          out_pass_nxt    = '0;
          state_nxt       = ST_IDLE;
        end
      end
      ST_E_RD: begin
        c_re      = 1'b1;
        s_re      = 1'b1;
        state_nxt = ST_E_CHK;
      end
      ST_E_CHK: begin
        if (count_r[i_r] == '0) begin
          newv_nxt  = c_rd_r;
          state_nxt = ST_E_WR;
        end else begin
          div_num_nxt = sum_abs;
          div_neg_nxt = sum_old[SUM_W-1];
          div_den_nxt = count_r[i_r];
          div_rem_nxt = '0;
          div_cnt_nxt = DCNT_W'(SUM_W);
          state_nxt   = ST_E_DIV;
        end
      end
      ST_E_DIV: begin
        if (div_cnt_r == '0) begin
          // The quotient of a mean of 32-bit values fits in 32 bits.
          newv_nxt  = div_neg_r ? (~div_num_r[COORD_W-1:0] + COORD_W'(1))
                                : div_num_r[COORD_W-1:0];
          state_nxt = ST_E_WR;
        end else begin
          if (rem_sh >= {1'b0, div_den_r}) begin
            div_rem_nxt = rem_sh - {1'b0, div_den_r};
            div_num_nxt = {div_num_r[SUM_W-2:0], 1'b1};
          end else begin
            div_rem_nxt = rem_sh;
            div_num_nxt = {div_num_r[SUM_W-2:0], 1'b0};
          end
          div_cnt_nxt = div_cnt_r - DCNT_W'(1);
        end
      end
      ST_E_WR: begin
        c_we = 1'b1;
        if (conv_mag > 33'(change_threshold_r)) begin
          changed_nxt = 1'b1;
        end
        if (last_j) begin
          j_nxt = '0;
          if (last_i) begin
            state_nxt = ST_E_EMIT;
          end else begin
            i_nxt     = i_r + CI_W'(1);
            state_nxt = ST_E_RD;
          end
        end else begin
          j_nxt     = j_r + DI_W'(1);
          state_nxt = ST_E_RD;
        end
      end
      ST_E_EMIT: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_kind_nxt    = KIND_STATUS;
          out_cluster_nxt = '0;
          out_value_nxt   = '0;
          out_conv_nxt    = !changed_r || (passes_done_r >= max_passes_r);
          passes_done_nxt = (passes_done_r == 8'hFF) ? passes_done_r
                                                     : passes_done_r + 8'd1;
          out_pass_nxt    = passes_done_nxt;
          first_pass_nxt  = 1'b0;
          pass_clear      = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r            <= ST_IDLE;
      cluster_count_r    <= 5'd4;
      dimension_count_r  <= 5'd16;
      change_threshold_r <= THR_W'(3277);
      max_passes_r       <= 8'd10;
      passes_done_r      <= '0;
      first_pass_r       <= 1'b1;
      out_valid_r        <= 1'b0;
      sum_vld_r          <= '0;
      for (int c = 0; c < MAX_CLUSTERS; c++) begin
        count_r[c] <= '0;
      end
    end else begin
      state_r       <= state_nxt;
      passes_done_r <= passes_done_nxt;
      first_pass_r  <= first_pass_nxt;
      out_valid_r   <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (kcp_cfg_t'(cfg_index))
          CFG_CLUSTERS:  cluster_count_r    <= cfg_data[4:0];
          CFG_DIMS:      dimension_count_r  <= cfg_data[4:0];
          CFG_THRESHOLD: change_threshold_r <= cfg_data[THR_W-1:0];
          CFG_MAXPASS:   max_passes_r       <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (pass_clear) begin
        sum_vld_r <= '0;
        for (int c = 0; c < MAX_CLUSTERS; c++) begin
          count_r[c] <= '0;
        end
      end else begin
        if (vld_set) begin
          sum_vld_r[s_waddr] <= 1'b1;
        end
        if (cnt_inc) begin
          count_r[best_r] <= count_r[best_r] + CNT_W'(1);
        end
      end
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk) begin
    i_r           <= i_nxt;
    j_r           <= j_nxt;
    best_r        <= best_nxt;
    acc_r         <= acc_nxt;
    best_dist_r   <= best_dist_nxt;
    mag_r         <= mag_nxt;
    sq_r          <= sq_nxt;
    newv_r        <= newv_nxt;
    changed_r     <= changed_nxt;
    div_num_r     <= div_num_nxt;
    div_rem_r     <= div_rem_nxt;
    div_den_r     <= div_den_nxt;
    div_neg_r     <= div_neg_nxt;
    div_cnt_r     <= div_cnt_nxt;
    rd_ok_r       <= rd_ok_nxt;
    out_kind_r    <= out_kind_nxt;
    out_cluster_r <= out_cluster_nxt;
    out_value_r   <= out_value_nxt;
    out_conv_r    <= out_conv_nxt;
    out_pass_r    <= out_pass_nxt;
    if (s_re) begin
      s_rd_vld_r <= sum_vld_r[s_raddr];
    end
    if (pbuf_we) begin
      pbuf_r[pbuf_waddr] <= in_coordinate;
    end
  end

  `KCP_ASSERT_NOW(a_div_den_nonzero, state_r == ST_E_DIV, div_den_r != '0, "divide by empty count")
  `KCP_ASSERT_NOW(a_best_in_use, state_r == ST_P_EMIT, 32'(best_r) <= k_last, "best cluster out of use")
  `KCP_ASSERT_NOW(a_dim_in_use, state_r == ST_D_ACC, 32'(j_r) <= d_last, "distance dim out of range")
  `KCP_ASSERT_NEXT(a_pass_done, state_r == ST_E_EMIT && out_free, !first_pass_r && passes_done_r != '0, "pass state not advanced")

endmodule
